// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the RTL; they compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- rtl/iptc_pkg.sv -----
// ----------------------------------------------------------------------------
// iptc_pkg
// Types, character codes and helper functions of the infix to postfix
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iptc_pkg;

	// default operator stack depth
	localparam int STACK_DEPTH_DEF = 16;

	// command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;

	// characters with a meaning of their own
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	// command kinds
	localparam logic [1:0] KIND_LETTER = 2'd0;
	localparam logic [1:0] KIND_LPAR   = 2'd1;
	localparam logic [1:0] KIND_RPAR   = 2'd2;
	localparam logic [1:0] KIND_OPER   = 2'd3;

	// operator precedence levels
	localparam logic [1:0] PREC_LOW = 2'd0;
	localparam logic [1:0] PREC_ADD = 2'd1;
	localparam logic [1:0] PREC_MUL = 2'd2;

	// classified word handed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] prec;
		logic [7:0] ch;
		logic       last;
	} iptc_cmd_t;

	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = PREC_LOW;
		if (c == CH_PLUS || c == CH_MINUS) begin
			p = PREC_ADD;
		end else if (c == CH_MUL || c == CH_DIV) begin
			p = PREC_MUL;
		end
		return p;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
	endfunction

endpackage

`default_nettype wire

// ----- rtl/infix_to_postfix_converter_unit.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter from an infix character stream to postfix output.
// ----------------------------------------------------------------------------
// One ASCII character enters per input word; letters are passed on, brackets
// and operators are ordered through an operator stack of STACK_DEPTH entries,
// and a word with tlast set ends the expression and flushes the stack. Each
// input word gives zero or more output words; tlast marks the last of them.
// After each pop the engine waits for the stack RAM read that fetches the new
// top; this holds for operators popped, the matching '(' discarded and each
// stack entry flushed at tlast. Output stalls hold the engine. A two-word
// queue lets input be taken while the stack engine works or the output is
// stalled. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix_converter_unit #(
	parameter int STACK_DEPTH = iptc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  wire logic       s_axis_tlast,   // end_of_expr
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_char
	output logic            m_axis_tlast,   // last_of_run
	output logic [7:0]      m_axis_tuser    // [0] has_char [1] expr_done [2] overflow
);
	import iptc_pkg::*;

	iptc_cmd_t cmd;
	logic      cmd_valid;
	logic      cmd_ready;

	// classifier and queue
	iptc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	// stack engine
	iptc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ----- rtl/iptc_ram.sv -----
// ----------------------------------------------------------------------------
// iptc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/iptc_front.sv -----
// ----------------------------------------------------------------------------
// iptc_front
// Accepts input words, classifies each character and queues the result
// for the stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iptc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,  // [7:0] char_code
	input  wire logic               s_axis_tlast,  // end_of_expr
	output logic                    cmd_valid,
	input  wire logic               cmd_ready,
	output iptc_pkg::iptc_cmd_t     cmd
);
	import iptc_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	iptc_cmd_t      queue_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	iptc_cmd_t      in_cmd;
	logic           wr_en;
	logic           rd_en;

	// classify the incoming character
	always_comb begin
		in_cmd.ch   = s_axis_tdata;
		in_cmd.last = s_axis_tlast;
		in_cmd.prec = prec_of(s_axis_tdata);
		if (is_letter(s_axis_tdata)) begin
			in_cmd.kind = KIND_LETTER;
		end else if (s_axis_tdata == CH_LPAR) begin
			in_cmd.kind = KIND_LPAR;
		end else if (s_axis_tdata == CH_RPAR) begin
			in_cmd.kind = KIND_RPAR;
		end else begin
			in_cmd.kind = KIND_OPER;
		end
	end

	assign s_axis_tready = (fill_q != QCW'(QUEUE_DEPTH));
	assign cmd_valid     = (fill_q != '0);
	assign cmd           = queue_q[rd_ptr_q];
	assign wr_en         = s_axis_tvalid && s_axis_tready;
	assign rd_en         = cmd_valid && cmd_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iptc_back.sv -----
// ----------------------------------------------------------------------------
// iptc_back
// Stack engine: runs the shunting-yard rules on queued words, keeps the
// operator stack in RAM with the top cached, and drives the output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module iptc_back #(
	parameter int STACK_DEPTH = iptc_pkg::STACK_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire iptc_pkg::iptc_cmd_t cmd,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [7:0]              m_axis_tdata,  // [7:0] out_char
	output logic                    m_axis_tlast,  // last_of_run
	output logic [7:0]              m_axis_tuser   // [0] has_char [1] expr_done [2] overflow
);
	import iptc_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OPER  = 3'd1;
	localparam logic [2:0] S_RPAR  = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_WAIT  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [2:0]    ret_q, ret_d;
	logic [2:0]    post_q;
	logic [CW-1:0] count_q;
	logic [7:0]    top_q;
	logic [1:0]    cmd_prec_q;
	logic [7:0]    cmd_ch_q;
	logic          cmd_end_q;
	logic          ovf_q;
	logic          held_valid_q;
	logic [7:0]    held_ch_q;
	logic          out_valid_q;
	logic [7:0]    out_ch_q;
	logic          out_has_q, out_last_q, out_done_q, out_ovf_q;

	logic          step_en;
	logic          empty, full;
	logic          do_emit, do_pop, do_push, set_ovf, fin;
	logic [7:0]    emit_ch, push_ch;
	logic          load_out;
	logic [2:0]    post_in;
	logic [CW-1:0] cnt_m2;
	logic [7:0]    rdata;

	assign step_en = !out_valid_q || m_axis_tready;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(STACK_DEPTH));
	assign post_in = cmd.last ? S_FLUSH : S_FIN;
	assign post_q  = cmd_end_q ? S_FLUSH : S_FIN;
	assign cnt_m2  = count_q - CW'(2);

	// stack body below the cached top
	iptc_ram #(
		.WIDTH (8),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (do_push),
		.waddr (count_q[AW-1:0]),
		.wdata (push_ch),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (rdata)
	);

	// sequencer decisions
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		do_emit   = 1'b0;
		emit_ch   = top_q;
		do_pop    = 1'b0;
		do_push   = 1'b0;
		push_ch   = cmd_ch_q;
		set_ovf   = 1'b0;
		cmd_ready = 1'b0;
		fin       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (step_en && cmd_valid) begin
					cmd_ready = 1'b1;
					unique case (cmd.kind)
						KIND_LETTER: begin
							do_emit = 1'b1;
							emit_ch = cmd.ch;
							state_d = post_in;
						end
						KIND_LPAR: begin
							push_ch = cmd.ch;
							if (full) begin
								set_ovf = 1'b1;
							end else begin
								do_push = 1'b1;
							end
							state_d = post_in;
						end
						KIND_RPAR: state_d = S_RPAR;
						KIND_OPER: state_d = S_OPER;
					endcase
				end
			end
			S_OPER: begin
				if (step_en) begin
					if (!empty && top_q != CH_LPAR && prec_of(top_q) >= cmd_prec_q) begin
						do_emit = 1'b1;
						do_pop  = 1'b1;
						ret_d   = S_OPER;
						state_d = S_WAIT;
					end else begin
						if (full) begin
							set_ovf = 1'b1;
						end else begin
							do_push = 1'b1;
						end
						state_d = post_q;
					end
				end
			end
			S_RPAR: begin
				if (step_en) begin
					if (empty) begin
						state_d = post_q;
					end else if (top_q == CH_LPAR) begin
						do_pop  = 1'b1;
						ret_d   = post_q;
						state_d = S_WAIT;
					end else begin
						do_emit = 1'b1;
						do_pop  = 1'b1;
						ret_d   = S_RPAR;
						state_d = S_WAIT;
					end
				end
			end
			S_FLUSH: begin
				if (step_en) begin
					if (empty) begin
						state_d = S_FIN;
					end else begin
						// a left parenthesis left over is dropped silently
						do_emit = (top_q != CH_LPAR);
						do_pop  = 1'b1;
						ret_d   = S_FLUSH;
						state_d = S_WAIT;
					end
				end
			end
			// new top arrives from the RAM; never stalled
			S_WAIT: state_d = ret_q;
			S_FIN: begin
				if (step_en) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// a held word goes out once the next one is known, or at the end of the run
	assign load_out = (do_emit && held_valid_q) ||
		(fin && (held_valid_q || cmd_end_q || ovf_q));

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (do_push) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd_ready) begin
				ovf_q <= set_ovf;
			end else if (set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (do_emit) begin
				held_valid_q <= 1'b1;
			end else if (fin) begin
				held_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_ready) begin
			cmd_prec_q <= cmd.prec;
			cmd_ch_q   <= cmd.ch;
			cmd_end_q  <= cmd.last;
		end
		if (do_push) begin
			top_q <= push_ch;
		end else if (state_q == S_WAIT) begin
			top_q <= rdata;
		end
		if (do_emit) begin
			held_ch_q <= emit_ch;
		end
		if (load_out) begin
			out_ch_q   <= held_valid_q ? held_ch_q : 8'h00;
			out_has_q  <= held_valid_q;
			out_last_q <= fin;
			out_done_q <= fin && cmd_end_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_ch_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {5'b0, out_ovf_q, out_done_q, out_has_q};

	// checks
	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(STACK_DEPTH))
	`ASSERT_PROP(a_wait_after_pop, clk, arst_n, (state_q == S_WAIT) |-> ($past(count_q) == count_q + 1'b1))
	`ASSERT_PROP(a_idle_nothing_held, clk, arst_n, (state_q == S_IDLE) |-> !held_valid_q)
	`ASSERT_PROP(a_load_only_when_free, clk, arst_n, load_out |-> step_en)

endmodule

`default_nettype wire

// ----- verif/infix_to_postfix_converter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test
// Self-checking bench for the shunting-yard infix to postfix converter.
// ----------------------------------------------------------------------------
// Characters are streamed in as words, each one also fed to a behavioural
// model of the operator stack that queues the postfix words it should release.
// Every output word is compared field by field with the oldest queued word.
// Stimulus is a directed opener and then random expressions (mostly well
// formed, some broken, some noise), run under several idle and stall mixes,
// with one long output hold-off that backs the input up.
// ----------------------------------------------------------------------------

import iptc_pkg::*;

// one output word as the bench expects it
typedef struct packed {
	logic [7:0] ch;
	logic       last;
	logic [7:0] flags;
} postfix_word_t;

class postfix_scoreboard;
	localparam int DEPTH    = STACK_DEPTH_DEF;
	localparam int FLAG_HAS = 0;
	localparam int FLAG_END = 1;
	localparam int FLAG_OVF = 2;

	logic [7:0]    op_stack [DEPTH];
	int unsigned   depth_used;
	postfix_word_t expected_q [$];
	int            errors;

	function new();
		depth_used = 0;
		errors     = 0;
	endfunction

	function bit is_alpha(logic [7:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	function int rank(logic [7:0] c);
		case (c)
			CH_PLUS, CH_MINUS: return 1;
			CH_MUL, CH_DIV:    return 2;
			default:           return 0;
		endcase
	endfunction

	function postfix_word_t char_word(logic [7:0] c);
		postfix_word_t w;
		w                = '0;
		w.ch             = c;
		w.flags[FLAG_HAS] = 1'b1;
		return w;
	endfunction

	// returns 0 when the stack is full and the character is lost
	function bit push_op(logic [7:0] c);
		if (depth_used >= DEPTH) begin
			return 1'b0;
		end
		op_stack[depth_used] = c;
		depth_used++;
		return 1'b1;
	endfunction

	// work out the words released by one accepted character
	function void note_char(logic [7:0] c, logic eoe);
		postfix_word_t run [$];
		postfix_word_t w;
		bit            dropped;
		int            r;
		dropped = 1'b0;
		if (is_alpha(c)) begin
			run.push_back(char_word(c));
		end else if (c == CH_LPAR) begin
			dropped = !push_op(c);
		end else if (c == CH_RPAR) begin
			while (depth_used > 0 && op_stack[depth_used - 1] != CH_LPAR) begin
				run.push_back(char_word(op_stack[depth_used - 1]));
				depth_used--;
			end
			// discard the matching bracket, if any
			if (depth_used > 0) begin
				depth_used--;
			end
		end else begin
			r = rank(c);
			while (depth_used > 0 && op_stack[depth_used - 1] != CH_LPAR &&
					rank(op_stack[depth_used - 1]) >= r) begin
				run.push_back(char_word(op_stack[depth_used - 1]));
				depth_used--;
			end
			dropped = !push_op(c);
		end
		// end of expression: flush, open brackets vanish
		if (eoe) begin
			while (depth_used > 0) begin
				if (op_stack[depth_used - 1] != CH_LPAR) begin
					run.push_back(char_word(op_stack[depth_used - 1]));
				end
				depth_used--;
			end
		end
		if (run.size() == 0 && (eoe || dropped)) begin
			w = '0;
			run.push_back(w);
		end
		foreach (run[i]) begin
			run[i].flags[FLAG_OVF] = dropped;
			if (i == run.size() - 1) begin
				run[i].last            = 1'b1;
				run[i].flags[FLAG_END] = eoe;
			end
			expected_q.push_back(run[i]);
		end
	endfunction

	function void fault(string msg);
		errors++;
		if (errors <= 10) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endfunction

	function void check_word(logic [7:0] d, logic l, logic [7:0] u);
		postfix_word_t w;
		if (expected_q.size() == 0) begin
			fault($sformatf("word tdata=%h tlast=%b tuser=%h with none expected", d, l, u));
			return;
		end
		w = expected_q.pop_front();
		if (d !== w.ch) begin
			fault($sformatf("tdata exp %h got %h", w.ch, d));
		end
		if (l !== w.last) begin
			fault($sformatf("tlast exp %b got %b (tdata %h)", w.last, l, w.ch));
		end
		if (u !== w.flags) begin
			fault($sformatf("tuser exp %h got %h (tdata %h)", w.flags, u, w.ch));
		end
	endfunction
endclass

module infix_to_postfix_converter_unit_test;

	localparam int LIMIT_CYCLES = 400000;
	localparam int PHASE_ITEMS  = 40;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic [7:0] m_axis_tuser;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_cycles   = 0;
	int items_sent    = 0;
	int cycle_count   = 0;

	logic [7:0]        expr_q [$];
	postfix_scoreboard sb = new();

	infix_to_postfix_converter_unit #(
		.STACK_DEPTH(STACK_DEPTH_DEF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("infix_to_postfix_converter_unit_test failed");
			$finish;
		end
	end

	// output side: check accepted words, then pick the next tready
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(1, 100) > snk_stall_pct);
			end
		end
	end

	// offer one word and wait for it to be taken; tvalid stays up afterwards
	task automatic send_word(input logic [7:0] c, input logic eoe);
		while ($urandom_range(1, 100) <= src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eoe;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_char(c, eoe);
		items_sent++;
	endtask

	task automatic send_expr(input bit with_end);
		foreach (expr_q[i]) begin
			send_word(expr_q[i], with_end && (i == expr_q.size() - 1));
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] c;
		c = 8'($urandom_range(0, 25));
		return $urandom_range(0, 1) ? CH_UC_A + c : CH_LC_A + c;
	endfunction

	// mostly the four arithmetic operators, sometimes any byte that is neither a letter nor a bracket
	function automatic logic [7:0] pick_op();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1:    c = CH_PLUS;
			2, 3:    c = CH_MINUS;
			4, 5:    c = CH_MUL;
			6, 7:    c = CH_DIV;
			default: begin
				c = 8'($urandom_range(0, 255));
				while (sb.is_alpha(c) || c == CH_LPAR || c == CH_RPAR) begin
					c = 8'($urandom_range(0, 255));
				end
			end
		endcase
		return c;
	endfunction

	function automatic void add_term(int lvl);
		if (lvl > 0 && $urandom_range(0, 2) == 0) begin
			expr_q.push_back(CH_LPAR);
			add_expr(lvl - 1);
			expr_q.push_back(CH_RPAR);
		end else begin
			expr_q.push_back(pick_letter());
		end
	endfunction

	function automatic void add_expr(int lvl);
		int n;
		n = $urandom_range(0, 3);
		add_term(lvl);
		repeat (n) begin
			expr_q.push_back(pick_op());
			add_term(lvl);
		end
	endfunction

	// deep bracket nesting, overruns the stack when n is at least its depth
	task automatic send_deep(input int n);
		int m;
		m = $urandom_range(0, n);
		expr_q.delete();
		repeat (n) expr_q.push_back(CH_LPAR);
		expr_q.push_back(pick_letter());
		expr_q.push_back(pick_op());
		expr_q.push_back(pick_letter());
		repeat (m) expr_q.push_back(CH_RPAR);
		send_expr(1'b1);
	endtask

	task automatic run_random(input int n_items);
		int stop_at;
		int pick;
		int idx;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_deep($urandom_range(10, 20));
			end else if (pick < 88) begin
				expr_q.delete();
				add_expr($urandom_range(0, 3));
				if (pick < 72) begin
					send_expr(1'b1);
				end else begin
					// broken: lose a character, add a stray bracket, or miss the end
					idx = $urandom_range(0, expr_q.size() - 1);
					case ($urandom_range(0, 3))
						0: if (expr_q.size() > 1) expr_q.delete(idx);
						1: expr_q.insert(idx, CH_RPAR);
						2: expr_q.insert(idx, CH_LPAR);
						default: ;
					endcase
					send_expr(1'($urandom_range(0, 1)));
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
			end
		end
	endtask

	// opener: brackets on an empty stack, all operator classes, byte extremes
	logic [8:0] opener [20] = '{
		{1'b0, CH_RPAR}, {1'b0, 8'h41},   {1'b0, CH_PLUS}, {1'b0, CH_LPAR},
		{1'b0, 8'h37},   {1'b0, CH_MUL},  {1'b0, 8'h7A},   {1'b0, CH_RPAR},
		{1'b0, CH_MINUS}, {1'b0, 8'h61},  {1'b0, CH_DIV},  {1'b1, 8'h5A},
		{1'b1, CH_LPAR}, {1'b0, 8'h00},   {1'b0, 8'hFF},   {1'b0, CH_PLUS},
		{1'b0, CH_RPAR}, {1'b1, 8'h62},   {1'b1, CH_RPAR}, {1'b1, 8'h80}
	};

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no idling on either side
		foreach (opener[i]) begin
			send_word(opener[i][7:0], opener[i][8]);
		end
		send_deep(STACK_DEPTH_DEF + 2);
		run_random(PHASE_ITEMS);
		drain();

		// long output hold-off while input keeps coming
		hold_cycles = 300;
		run_random(25);
		drain();

		src_idle_pct  = 77;
		snk_stall_pct = 0;
		run_random(PHASE_ITEMS);
		drain();

		src_idle_pct  = 0;
		snk_stall_pct = 77;
		run_random(PHASE_ITEMS);
		drain();

		src_idle_pct  = 23;
		snk_stall_pct = 23;
		run_random(PHASE_ITEMS);
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("infix_to_postfix_converter_unit_test passed");
		end else begin
			$display("infix_to_postfix_converter_unit_test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/iptc_pkg.sv
rtl/iptc_ram.sv
rtl/iptc_front.sv
rtl/iptc_back.sv
rtl/infix_to_postfix_converter_unit.sv
verif/infix_to_postfix_converter_unit_test.sv
